@@ rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

@@ rtl/mfsd_pkg.sv @@
// Package for the Mahalanobis forward-solve block: widths, codes, types.
// No dependencies.
package mfsd_pkg;
    localparam int MAX_DIM = 16;
    localparam int IDX_W = 4;
    localparam int FAC_AW = 8;

    localparam logic [1:0] OP_LOAD_FACTOR = 2'd0;
    localparam logic [1:0] OP_LOAD_MEAN   = 2'd1;
    localparam logic [1:0] OP_SAMPLE      = 2'd2;

    localparam logic CFG_DIM    = 1'b0;
    localparam logic CFG_OFFSET = 1'b1;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [IDX_W-1:0]  row_index;
        logic [IDX_W-1:0]  col_index;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [47:0]        squared_distance;
        logic signed [47:0] log_density;
        logic               status;
    } out_item_t;

    typedef struct packed {
        logic        index;
        logic [31:0] data;
    } cfg_item_t;
endpackage

@@ rtl/mfsd_if.sv @@
// Valid/ready channel interfaces for items, results and configuration.
// Depends on mfsd_pkg.
interface mfsd_in_if;
    import mfsd_pkg::*;
    logic valid;
    logic ready;
    in_item_t data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface mfsd_out_if;
    import mfsd_pkg::*;
    logic valid;
    logic ready;
    out_item_t data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface mfsd_cfg_if;
    import mfsd_pkg::*;
    logic valid;
    logic ready;
    cfg_item_t data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

@@ rtl/mfsd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module mfsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/mahalanobis_forward_solve_density_top.sv @@
// Squared Mahalanobis distance and Gaussian log density by forward
// substitution against a lower-triangular factor, Q16.16 in, Q32.16 out.
// A load transaction is accepted in the idle state and then passes through a
// load state. A sample element at index r is accepted, then takes r
// multiply-accumulates through the factor and solved-value memories (one read
// per cycle), reads the diagonal, runs a 64-step restoring divider, then the
// square-sum update. The last element of a sample then loads the output
// register, and waits for it while an earlier result is unread.
// One item is in work at a time; a finished result waits in the output
// register without blocking the next item.
// Depends on mfsd_pkg, mfsd_if, mfsd_ram and assert_macros.svh.
`include "assert_macros.svh"
module mahalanobis_forward_solve_density_top (
    input  logic     clk,
    input  logic     rst_n,
    mfsd_in_if.sink  in_ch,
    mfsd_out_if.source out_ch,
    mfsd_cfg_if.sink cfg
);
    import mfsd_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAC  = 3'd1;
    localparam logic [2:0] S_MACW = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;
    localparam logic [2:0] S_LOAD = 3'd6;

    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

    logic [2:0]  state_reg, state_next;
    logic [4:0]  dim_reg;
    logic signed [31:0] offset_reg;
    logic        bad_reg;
    logic [47:0] sum_reg;
    logic [IDX_W-1:0] row_reg;
    logic [IDX_W-1:0] i_reg;
    logic signed [31:0] x_reg;
    logic        last_reg;
    logic signed [63:0] acc_reg;
    logic [5:0]  dcnt_reg;
    logic [64:0] rem_reg;
    logic [63:0] quo_reg;
    logic [63:0] quo_next;
    logic [63:0] num_abs_reg;
    logic        neg_reg;
    logic signed [31:0] diag_reg;
    logic signed [31:0] t_reg;
    logic        ovalid_reg;
    out_item_t   odata_reg;

    // memories
    logic              fac_we, mean_we, sol_we;
    logic [FAC_AW-1:0] fac_waddr, fac_raddr;
    logic [IDX_W-1:0]  mean_waddr, mean_raddr, sol_waddr, sol_raddr;
    logic [31:0]       fac_wdata, mean_wdata, sol_wdata;
    logic [31:0]       fac_rdata, mean_rdata, sol_rdata;

    mfsd_ram #(.WIDTH(32), .DEPTH(MAX_DIM*MAX_DIM)) u_fac (
        .clk(clk), .we(fac_we), .waddr(fac_waddr), .wdata(fac_wdata),
        .raddr(fac_raddr), .rdata(fac_rdata));
    mfsd_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_mean (
        .clk(clk), .we(mean_we), .waddr(mean_waddr), .wdata(mean_wdata),
        .raddr(mean_raddr), .rdata(mean_rdata));
    mfsd_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_sol (
        .clk(clk), .we(sol_we), .waddr(sol_waddr), .wdata(sol_wdata),
        .raddr(sol_raddr), .rdata(sol_rdata));

    logic [4:0] dim_eff;
    logic       in_fire, cfg_fire;
    logic signed [63:0] prod, acc_sum, diff64, num64;
    logic [64:0] rem_shift;
    logic [64:0] rem_sub;
    logic signed [64:0] q_signed;
    logic signed [31:0] t_sat;
    logic [63:0] t_sq;
    logic [48:0] sum_add;
    logic [47:0] sum_new;
    logic signed [49:0] ld_wide;

    assign dim_eff = (dim_reg == 5'd0) ? 5'd1 :
                     (dim_reg > 5'(MAX_DIM)) ? 5'(MAX_DIM) : dim_reg;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_fire = in_ch.valid && in_ch.ready;
    assign cfg.ready = 1'b1;
    assign cfg_fire = cfg.valid;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data = odata_reg;

    // memory addressing
    always_comb
    begin
        fac_we = in_fire && in_ch.data.opcode == OP_LOAD_FACTOR;
        fac_waddr = {in_ch.data.row_index, in_ch.data.col_index};
        fac_wdata = in_ch.data.value;
        mean_we = in_fire && in_ch.data.opcode == OP_LOAD_MEAN;
        mean_waddr = in_ch.data.row_index;
        mean_wdata = in_ch.data.value;
        sol_we = (state_reg == S_SUM);
        sol_waddr = row_reg;
        sol_wdata = t_reg;
        sol_raddr = i_reg;
        mean_raddr = row_reg;
        fac_raddr = (state_reg == S_MAC) ? {row_reg, i_reg} : {row_reg, row_reg};
        if (state_reg == S_IDLE)
        begin
            // first tap of the row; for row 0 this is the diagonal
            fac_raddr = {in_ch.data.row_index, 4'd0};
            sol_raddr = '0;
            mean_raddr = in_ch.data.row_index;
        end
    end

    // datapath
    assign prod = 64'(signed'(sol_rdata)) * 64'(signed'(fac_rdata));
    always_comb
    begin
        logic signed [64:0] s;
        s = 65'(acc_reg) + 65'(prod);
        acc_sum = (s > 65'(S64_MAX)) ? S64_MAX : (s < 65'(S64_MIN)) ? S64_MIN : s[63:0];
    end
    assign diff64 = (64'(x_reg) - 64'(signed'(mean_rdata))) <<< 16;
    always_comb
    begin
        logic signed [64:0] s;
        s = 65'(diff64) - 65'(acc_reg);
        num64 = (s > 65'(S64_MAX)) ? S64_MAX : (s < 65'(S64_MIN)) ? S64_MIN : s[63:0];
    end
    assign rem_shift = {rem_reg[63:0], num_abs_reg[63]};
    assign rem_sub = rem_shift - {33'd0, diag_reg};
    assign quo_next = {quo_reg[62:0], !rem_sub[64]};
    assign q_signed = neg_reg ? -$signed({1'b0, quo_next}) : $signed({1'b0, quo_next});
    assign t_sat = (q_signed > 65'sd2147483647) ? 32'sh7fffffff :
                   (q_signed < -65'sd2147483648) ? 32'sh80000000 : q_signed[31:0];
    assign t_sq = 64'(t_reg) * 64'(t_reg);
    assign sum_add = ((row_reg == '0) ? 49'd0 : {1'b0, sum_reg}) + {1'b0, t_sq[63:16]};
    assign sum_new = sum_add[48] ? {48{1'b1}} : sum_add[47:0];
    assign ld_wide = -$signed({2'b00, sum_reg[47:1]}) - 50'(offset_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_ch.data.opcode == OP_SAMPLE &&
                        5'(in_ch.data.row_index) < dim_eff)
                    begin
                        state_next = (in_ch.data.row_index == '0) ? S_MACW : S_MAC;
                    end
                    else if (in_ch.data.opcode != OP_SAMPLE)
                    begin
                        state_next = S_LOAD;
                    end
                end
            end
            S_MAC:  state_next = (i_reg == row_reg) ? S_MACW : S_MAC;
            S_MACW: state_next = S_DIV;
            S_DIV:  state_next = (dcnt_reg == 6'd0) ? S_SUM : S_DIV;
            S_SUM:  state_next = last_reg ? S_EMIT : S_IDLE;
            S_EMIT: state_next = ovalid_reg ? S_EMIT : S_IDLE;
            S_LOAD: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dim_reg <= 5'd16;
            offset_reg <= '0;
            bad_reg <= 1'b0;
            sum_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_fire)
            begin
                if (cfg.data.index == CFG_DIM)
                begin
                    dim_reg <= cfg.data.data[4:0];
                end
                else
                begin
                    offset_reg <= cfg.data.data;
                end
            end
            if (fac_we && in_ch.data.row_index == in_ch.data.col_index &&
                in_ch.data.value <= 0)
            begin
                bad_reg <= 1'b1;
            end
            if (state_reg == S_SUM)
            begin
                sum_reg <= sum_new;
            end
            if (ovalid_reg && out_ch.ready)
            begin
                ovalid_reg <= 1'b0;
            end
            else if (state_reg == S_EMIT)
            begin
                ovalid_reg <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                row_reg <= in_ch.data.row_index;
                x_reg <= in_ch.data.value;
                last_reg <= (5'(in_ch.data.row_index) == dim_eff - 5'd1);
                i_reg <= (in_ch.data.row_index == '0) ? '0 : 4'd1;
                acc_reg <= '0;
            end
            S_MAC:
            begin
                acc_reg <= acc_sum;
                if (i_reg != row_reg)
                begin
                    i_reg <= i_reg + 4'd1;
                end
            end
            S_MACW:
            begin
                // all products are in acc_reg; diagonal on the read port
                diag_reg <= fac_rdata;
                neg_reg <= num64[63];
                num_abs_reg <= num64[63] ? 64'(-num64) : num64;
                rem_reg <= '0;
                quo_reg <= '0;
                dcnt_reg <= 6'd63;
            end
            S_DIV:
            begin
                if (!rem_sub[64])
                begin
                    rem_reg <= rem_sub;
                end
                else
                begin
                    rem_reg <= rem_shift;
                end
                quo_reg <= quo_next;
                num_abs_reg <= {num_abs_reg[62:0], 1'b0};
                if (dcnt_reg != 6'd0)
                begin
                    dcnt_reg <= dcnt_reg - 6'd1;
                end
                t_reg <= (diag_reg > 0) ? t_sat : '0;
            end
            S_SUM:
            begin
            end
            S_EMIT:
            begin
                if (!ovalid_reg)
                begin
                    odata_reg.status <= bad_reg;
                    odata_reg.squared_distance <= bad_reg ? '0 : sum_reg;
                    odata_reg.log_density <= bad_reg ? '0 :
                        (ld_wide > 50'sh7fffffffffff) ? 48'sh7fffffffffff :
                        (ld_wide < -50'sh800000000000) ? 48'sh800000000000 :
                        ld_wide[47:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    `ASSERT_IMPLIES(a_busy_not_ready, clk, rst_n, state_reg != S_IDLE, !in_ch.ready)
    `ASSERT_NEXT(a_sum_to_emit, clk, rst_n, state_reg == S_SUM && last_reg, state_reg == S_EMIT)
    `ASSERT_IMPLIES(a_bad_status, clk, rst_n, ovalid_reg && odata_reg.status, odata_reg.squared_distance == '0)
endmodule
